// ===== design/pwbd_pkg.sv =====
// ----------------------------------------------------------------------------
// pwbd_pkg
// Shared types and constants for the pulse width bit decoder.
// ----------------------------------------------------------------------------
package pwbd_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned PROD_W = 39;   // 32-bit magnitude times 7-bit factor
    localparam int unsigned IDX_W  = 7;
    localparam int unsigned TOL_W  = 7;

    localparam logic [TOL_W-1:0] PCT_SCALE = 7'd100;
    localparam logic [TOL_W-1:0] TOL_RESET = 7'd35;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_PWM  = 2'd1,
        MODE_PPM  = 2'd2,
        MODE_PAIR = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        REG_DECODE_MODE = 3'd0,
        REG_MARK_SHORT  = 3'd1,
        REG_MARK_LONG   = 3'd2,
        REG_MARK_COUNT  = 3'd3,
        REG_SPACE_SHORT = 3'd4,
        REG_SPACE_LONG  = 3'd5,
        REG_SPACE_COUNT = 3'd6,
        REG_TOLERANCE   = 3'd7
    } t_reg_idx;

    // Center set shared by both lanes
    typedef struct packed {
        logic [TIME_W-1:0] mark_short;
        logic [TIME_W-1:0] mark_long;
        logic [1:0]        mark_count;
        logic [TIME_W-1:0] space_short;
        logic [TIME_W-1:0] space_long;
        logic [1:0]        space_count;
        logic [TOL_W-1:0]  tolerance;
    } t_centers;

    // Stage load enables driven by the top-level pipeline control
    typedef struct packed {
        logic ld_a;
        logic ld_b;
        logic ld_c;
    } t_lane_ctl;

    typedef struct packed {
        logic known;
        logic is_long;
    } t_lane_res;

    // Per-transaction information that travels beside the lanes
    typedef struct packed {
        logic             used;
        logic [IDX_W-1:0] idx;
        logic             neg1;
        logic             neg2;
        t_mode            mode;
    } t_side;

endpackage

// ===== design/pwbd_lane.sv =====
// ----------------------------------------------------------------------------
// pwbd_lane
// One pulse classifier: magnitude, nearer center, tolerance check.
// ----------------------------------------------------------------------------
module pwbd_lane import pwbd_pkg::*; (
    input  logic              i_clk,
    input  logic [TIME_W-1:0] i_timing,
    input  t_centers          i_centers,
    input  t_lane_ctl         i_ctl,
    output t_lane_res         o_res
);

    // stage A: magnitude
    logic [TIME_W-1:0] r_a_mag;
    logic              r_a_mag_ok;
    logic              r_a_neg;

    logic              n_neg;
    logic [TIME_W-1:0] n_mag;
    logic              n_mag_ok;

    always_comb begin
        n_neg    = i_timing[TIME_W-1];
        n_mag    = n_neg ? (~i_timing + 1'b1) : i_timing;
        n_mag_ok = (i_timing != '0) && (i_timing != {1'b1, {(TIME_W-1){1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_a) begin
            r_a_mag    <= n_mag;
            r_a_mag_ok <= n_mag_ok;
            r_a_neg    <= n_neg;
        end
    end

    // stage B: distances to both centers, pick the nearer (short on a tie)
    logic [TIME_W-1:0] r_b_diff;
    logic [TIME_W-1:0] r_b_big;
    logic              r_b_long;
    logic              r_b_ok;

    logic [TIME_W-1:0] c_short, c_long;
    logic [1:0]        c_count;
    logic [TIME_W:0]   m_sub_s, s_sub_m, m_sub_l, l_sub_m;
    logic              mag_ge_s, mag_ge_l, pick_short;
    logic [TIME_W-1:0] d_lo, d_hi;
    logic [TIME_W-1:0] c_pick;
    logic [TIME_W-1:0] n_diff, n_big;
    logic              n_ok;

    always_comb begin
        c_short    = r_a_neg ? i_centers.space_short : i_centers.mark_short;
        c_long     = r_a_neg ? i_centers.space_long  : i_centers.mark_long;
        c_count    = r_a_neg ? i_centers.space_count : i_centers.mark_count;
        m_sub_s    = {1'b0, r_a_mag} - {1'b0, c_short};
        s_sub_m    = {1'b0, c_short} - {1'b0, r_a_mag};
        m_sub_l    = {1'b0, r_a_mag} - {1'b0, c_long};
        l_sub_m    = {1'b0, c_long}  - {1'b0, r_a_mag};
        mag_ge_s   = !m_sub_s[TIME_W];
        mag_ge_l   = !m_sub_l[TIME_W];
        d_lo       = mag_ge_s ? m_sub_s[TIME_W-1:0] : s_sub_m[TIME_W-1:0];
        d_hi       = mag_ge_l ? m_sub_l[TIME_W-1:0] : l_sub_m[TIME_W-1:0];
        pick_short = (d_lo <= d_hi);
        c_pick     = pick_short ? c_short : c_long;
        n_diff     = pick_short ? d_lo : d_hi;
        if (pick_short) begin
            n_big = mag_ge_s ? r_a_mag : c_short;
        end else begin
            n_big = mag_ge_l ? r_a_mag : c_long;
        end
        // count of 2 or 3 enables use; an all-ones center is the invalid marker
        n_ok = r_a_mag_ok && c_count[1] && (c_short != '0) && (c_long != '0)
               && (c_pick != '1);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_b) begin
            r_b_diff <= n_diff;
            r_b_big  <= n_big;
            r_b_long <= !pick_short;
            r_b_ok   <= n_ok;
        end
    end

    // stage C: scaled products; compare happens in the merge register stage
    logic [PROD_W-1:0] r_c_pd;
    logic [PROD_W-1:0] r_c_pb;
    logic              r_c_long;
    logic              r_c_ok;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_c) begin
            r_c_pd   <= PROD_W'(r_b_diff) * PROD_W'(PCT_SCALE);
            r_c_pb   <= PROD_W'(r_b_big) * PROD_W'(i_centers.tolerance);
            r_c_long <= r_b_long;
            r_c_ok   <= r_b_ok;
        end
    end

    assign o_res.known   = r_c_ok && (r_c_pd <= r_c_pb);
    assign o_res.is_long = r_c_long;

endmodule

// ===== design/pwbd_merge.sv =====
// ----------------------------------------------------------------------------
// pwbd_merge
// Combines both lane results by decode mode into the output register.
// ----------------------------------------------------------------------------
module pwbd_merge import pwbd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_ld,
    input  t_side            i_side,
    input  t_lane_res        i_lane1,
    input  t_lane_res        i_lane2,
    output logic [IDX_W-1:0] o_idx,
    output logic             o_bit,
    output logic             o_known,
    output logic             o_used
);

    logic [IDX_W-1:0] r_idx;
    logic             r_bit;
    logic             r_known;
    logic             r_used;

    t_lane_res sel;
    logic      n_known;
    logic      n_bit;

    always_comb begin
        sel     = i_lane1;
        n_known = 1'b0;
        n_bit   = 1'b0;
        unique case (i_side.mode)
            MODE_PWM: begin
                sel     = i_side.neg1 ? i_lane2 : i_lane1;   // the mark pulse
                n_known = sel.known;
                n_bit   = sel.is_long;
            end
            MODE_PPM: begin
                sel     = i_side.neg1 ? i_lane1 : i_lane2;   // the space pulse
                n_known = sel.known;
                n_bit   = sel.is_long;
            end
            MODE_PAIR: begin
                n_known = i_lane1.known && i_lane2.known
                          && (i_lane1.is_long != i_lane2.is_long);
                n_bit   = i_lane1.is_long;
            end
            MODE_OFF: begin
                n_known = 1'b0;
            end
            default: begin
                n_known = 1'b0;
            end
        endcase
        // pulses of equal polarity never classify
        n_known = n_known && i_side.used && (i_side.neg1 != i_side.neg2);
        n_bit   = n_bit && n_known;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_idx   <= i_side.idx;
            r_bit   <= n_bit;
            r_known <= n_known;
            r_used  <= i_side.used;
        end
    end

    assign o_idx   = r_idx;
    assign o_bit   = r_bit;
    assign o_known = r_known;
    assign o_used  = r_used;

endmodule

// ===== design/pulse_width_bit_decoder_core.sv =====
// ----------------------------------------------------------------------------
// pulse_width_bit_decoder_core
// OOK pulse pair to bit slot decoder (PWM, PPM, pulse pair).
// ----------------------------------------------------------------------------
// Input stream: one transaction per pulse pair. s_axis_tdata carries the two
// signed timings, s_axis_tuser flags the first pair of a frame.
// Output stream: one transaction per input pair with slot index, bit, known
// and slot-used flags.
// Two classifier lanes, one per pulse, work side by side; a merge stage picks
// the lane(s) the decode mode calls for.
// Four register stages (magnitude, nearer center, scaled products,
// compare/merge) lie between an accepted pair and its result.
// Throughput is one pair per cycle while m_axis_tready does not hold the output.
// Each stage loads when it is empty or the stage after it moves, so the block
// keeps taking pairs while a result waits, until all four stages are full.
// Configuration writes go through i_cfg_we/i_cfg_idx/i_cfg_wdata and take
// effect at once; write them only while the pipeline is empty.
// Synchronous reset clears the slot counter, all stage valids and the
// configuration registers (tolerance returns to 35 percent).
// ----------------------------------------------------------------------------
module pulse_width_bit_decoder_core import pwbd_pkg::*; #(
    parameter int unsigned BIT_CAPACITY = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] first_timing, [63:32] second_timing
    input  logic        s_axis_tuser,   // [0] frame_start
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [6:0] slot_pos, [7] bit_value,
                                        // [8] bit_known, [9] slot_used, [15:10] 0
);

    localparam int unsigned CNT_W = $clog2(BIT_CAPACITY + 1);

    // ---------------- configuration registers ----------------
    t_mode    r_mode;
    t_centers r_ctr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode            <= MODE_OFF;
            r_ctr.mark_short  <= '0;
            r_ctr.mark_long   <= '0;
            r_ctr.mark_count  <= '0;
            r_ctr.space_short <= '0;
            r_ctr.space_long  <= '0;
            r_ctr.space_count <= '0;
            r_ctr.tolerance   <= TOL_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_DECODE_MODE: r_mode            <= t_mode'(i_cfg_wdata[1:0]);
                REG_MARK_SHORT:  r_ctr.mark_short  <= i_cfg_wdata;
                REG_MARK_LONG:   r_ctr.mark_long   <= i_cfg_wdata;
                REG_MARK_COUNT:  r_ctr.mark_count  <= i_cfg_wdata[1:0];
                REG_SPACE_SHORT: r_ctr.space_short <= i_cfg_wdata;
                REG_SPACE_LONG:  r_ctr.space_long  <= i_cfg_wdata;
                REG_SPACE_COUNT: r_ctr.space_count <= i_cfg_wdata[1:0];
                REG_TOLERANCE:   r_ctr.tolerance   <= i_cfg_wdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic r_v_a, r_v_b, r_v_c, r_v_d;
    logic rdy_a, rdy_b, rdy_c, rdy_d;
    logic in_xfer;
    t_lane_ctl lane_ctl;

    always_comb begin
        rdy_d   = !r_v_d || m_axis_tready;
        rdy_c   = !r_v_c || rdy_d;
        rdy_b   = !r_v_b || rdy_c;
        rdy_a   = !r_v_a || rdy_b;
        in_xfer = s_axis_tvalid && rdy_a;
        lane_ctl.ld_a = rdy_a;
        lane_ctl.ld_b = rdy_b;
        lane_ctl.ld_c = rdy_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
            r_v_b <= 1'b0;
            r_v_c <= 1'b0;
            r_v_d <= 1'b0;
        end else begin
            if (rdy_a) r_v_a <= in_xfer;
            if (rdy_b) r_v_b <= r_v_a;
            if (rdy_c) r_v_c <= r_v_b;
            if (rdy_d) r_v_d <= r_v_c;
        end
    end

    // ---------------- slot counter ----------------
    logic [CNT_W-1:0]       r_slot_cnt;
    logic [CNT_W-1:0]       slot_eff;
    logic [CNT_W+IDX_W-1:0] slot_ext;
    logic                   slot_take;
    t_side                  n_side;

    always_comb begin
        slot_eff  = s_axis_tuser ? '0 : r_slot_cnt;
        slot_take = (r_mode != MODE_OFF) && (slot_eff < CNT_W'(BIT_CAPACITY));
        slot_ext  = {{IDX_W{1'b0}}, slot_eff};
        n_side.used = slot_take;
        n_side.idx  = slot_take ? slot_ext[IDX_W-1:0] : '0;
        n_side.neg1 = s_axis_tdata[31];
        n_side.neg2 = s_axis_tdata[63];
        n_side.mode = r_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_cnt <= '0;
        end else if (in_xfer) begin
            r_slot_cnt <= slot_take ? slot_eff + CNT_W'(1) : slot_eff;
        end
    end

    // side info rides along beside the lanes
    t_side r_side_a, r_side_b, r_side_c;

    always_ff @(posedge i_clk) begin
        if (rdy_a) r_side_a <= n_side;
        if (rdy_b) r_side_b <= r_side_a;
        if (rdy_c) r_side_c <= r_side_b;
    end

    // ---------------- lanes and merge ----------------
    t_lane_res lane1_res, lane2_res;

    pwbd_lane u_lane1 (
        .i_clk     (i_clk),
        .i_timing  (s_axis_tdata[31:0]),
        .i_centers (r_ctr),
        .i_ctl     (lane_ctl),
        .o_res     (lane1_res)
    );

    pwbd_lane u_lane2 (
        .i_clk     (i_clk),
        .i_timing  (s_axis_tdata[63:32]),
        .i_centers (r_ctr),
        .i_ctl     (lane_ctl),
        .o_res     (lane2_res)
    );

    logic [IDX_W-1:0] out_idx;
    logic             out_bit, out_known, out_used;

    pwbd_merge u_merge (
        .i_clk   (i_clk),
        .i_ld    (rdy_d),
        .i_side  (r_side_c),
        .i_lane1 (lane1_res),
        .i_lane2 (lane2_res),
        .o_idx   (out_idx),
        .o_bit   (out_bit),
        .o_known (out_known),
        .o_used  (out_used)
    );

    assign s_axis_tready = rdy_a;
    assign m_axis_tvalid = r_v_d;
    assign m_axis_tdata  = {6'b0, out_used, out_known, out_bit, out_idx};

    // ---------------- assertions ----------------
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot_cnt <= CNT_W'(BIT_CAPACITY))
        else $error("slot counter above capacity");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && s_axis_tuser && (r_mode != MODE_OFF)) |=> (r_slot_cnt == CNT_W'(1)))
        else $error("frame start did not restart slot count");

    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !out_used) |-> (out_idx == '0 && !out_bit && !out_known))
        else $error("unused slot carries data");

    a_unknown_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !out_known) |-> !out_bit)
        else $error("bit set while unknown");

endmodule
